>>> rtl/core/trpbb_pkg.sv
package trpbb_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int COORD_BITS = 12;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int REG_W      = 12;
  localparam int NUM_W      = COORD_BITS + 16;
  localparam int STEP_W     = $clog2(NUM_W);
  localparam int FRAC_W     = 16;

  // floor(n/10) as (n * K_RECIP) >> K_SHIFT, exact for n up to 4096
  localparam int K_RECIP = 3277;
  localparam int K_SHIFT = 15;

  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd0;
  localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd1;

  localparam logic [1:0] FSEL_CENTER_X = 2'd0;
  localparam logic [1:0] FSEL_CENTER_Y = 2'd1;
  localparam logic [1:0] FSEL_HEIGHT   = 2'd2;
  localparam logic [1:0] FSEL_WIDTH    = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_CMP,
    ST_WV,
    ST_AXDONE,
    ST_FRD0,
    ST_FRD1,
    ST_FRD2,
    ST_DLOAD,
    ST_DSTEP,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic sort_init;
    logic sort_cmp;
    logic sort_wv;
    logic axis_done;
    logic fin_rd0;
    logic fin_rd1;
    logic fin_rd2;
    logic div_load;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_full;
    logic last;
    logic axis;
    logic gt;
    logic pos_one;
    logic div_last;
    logic fsel_last;
  } status_t;

endpackage

>>> rtl/core/trpbb_ram.sv
module trpbb_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/trpbb_ctrl.sv
module trpbb_ctrl
  import trpbb_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy,
  output logic    out_valid
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (start) state_nxt = ST_INIT;
      ST_INIT: begin
        if (status.cnt_full) state_nxt = status.last ? ST_FRD0 : ST_IDLE;
        else if (status.cnt_zero) state_nxt = ST_WV;
        else state_nxt = ST_CMP;
      end
      ST_CMP:    state_nxt = (status.gt && !status.pos_one) ? ST_CMP : ST_WV;
      ST_WV:     state_nxt = ST_AXDONE;
      ST_AXDONE: begin
        if (!status.axis) state_nxt = ST_INIT;
        else state_nxt = status.last ? ST_FRD0 : ST_IDLE;
      end
      ST_FRD0:   state_nxt = ST_FRD1;
      ST_FRD1:   state_nxt = ST_FRD2;
      ST_FRD2:   state_nxt = ST_DLOAD;
      ST_DLOAD:  state_nxt = ST_DSTEP;
      ST_DSTEP: begin
        if (status.div_last) state_nxt = status.fsel_last ? ST_OUT : ST_DLOAD;
      end
      ST_OUT:    state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_INIT:   cmd.sort_init = 1'b1;
      ST_CMP:    cmd.sort_cmp  = 1'b1;
      ST_WV:     cmd.sort_wv   = 1'b1;
      ST_AXDONE: cmd.axis_done = 1'b1;
      ST_FRD0:   cmd.fin_rd0   = 1'b1;
      ST_FRD1:   cmd.fin_rd1   = 1'b1;
      ST_FRD2:   cmd.fin_rd2   = 1'b1;
      ST_DLOAD:  cmd.div_load  = 1'b1;
      ST_DSTEP:  cmd.div_step  = 1'b1;
      ST_OUT: begin
        cmd.finish = 1'b1;
        out_valid  = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

>>> rtl/core/trpbb_dp.sv
module trpbb_dp
  import trpbb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output status_t               status,
  input  logic [COORD_BITS-1:0] in_x_coord,
  input  logic [COORD_BITS-1:0] in_y_coord,
  input  logic                  in_is_last,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [REG_W-1:0]      cfg_wdata,
  output logic [FRAC_W-1:0]     out_center_x,
  output logic [FRAC_W-1:0]     out_center_y,
  output logic [FRAC_W-1:0]     out_height_frac,
  output logic [FRAC_W-1:0]     out_width_frac,
  output logic                  out_overflowed
);

  logic [REG_W-1:0]      height_r, width_r;
  logic [COORD_BITS-1:0] xv_r, yv_r;
  logic                  last_r, axis_r, drop_r;
  logic [CNT_W-1:0]      cnt_r, pos_r;
  logic [COORD_BITS-1:0] min_x_r, max_x_r, min_y_r, max_y_r;
  logic [NUM_W-1:0]      num_r, q_r;
  logic [REG_W-1:0]      rem_r, den_r;
  logic [STEP_W-1:0]     step_r;
  logic [1:0]            fsel_r;
  logic [FRAC_W-1:0]     cx_r, cy_r, hf_r, wf_r;

  logic [COORD_BITS-1:0] x_rdata, y_rdata, rdata, val;
  logic [ADDR_W-1:0]     raddr;
  logic                  wr_en;
  logic [COORD_BITS-1:0] wr_data;
  logic [CNT_W+11:0]     k_prod;
  logic [CNT_W-1:0]      k;
  logic [REG_W:0]        rem_s;
  logic                  q_bit;
  logic [NUM_W-1:0]      q_full;
  logic [FRAC_W-1:0]     q_sat;
  logic [NUM_W-1:0]      num_sel;
  logic [REG_W-1:0]      den_sel;

  assign rdata = axis_r ? y_rdata : x_rdata;
  assign val   = axis_r ? yv_r : xv_r;

  assign k_prod = CNT_W'(cnt_r) * 12'(K_RECIP);
  assign k      = CNT_W'(k_prod >> K_SHIFT);

  always_comb begin
    raddr = '0;
    if (cmd.sort_init) raddr = ADDR_W'(cnt_r - 1'b1);
    else if (cmd.sort_cmp) raddr = ADDR_W'(pos_r - 2'd2);
    else if (cmd.fin_rd0) raddr = ADDR_W'(k);
    else if (cmd.fin_rd1) raddr = ADDR_W'(cnt_r - 1'b1 - k);
  end

  // shift the larger entry up, or drop the new value into its slot
  assign wr_en   = (cmd.sort_cmp && status.gt) || cmd.sort_wv;
  assign wr_data = cmd.sort_wv ? val : rdata;

  trpbb_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_POINTS)) u_x_ram (
    .clk   (clk),
    .we    (wr_en && !axis_r),
    .waddr (ADDR_W'(pos_r)),
    .wdata (wr_data),
    .raddr (raddr),
    .rdata (x_rdata)
  );

  trpbb_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_POINTS)) u_y_ram (
    .clk   (clk),
    .we    (wr_en && axis_r),
    .waddr (ADDR_W'(pos_r)),
    .wdata (wr_data),
    .raddr (raddr),
    .rdata (y_rdata)
  );

  always_comb begin
    case (fsel_r)
      FSEL_CENTER_X: begin
        num_sel = NUM_W'({1'b0, min_x_r} + {1'b0, max_x_r}) << 15;
        den_sel = width_r;
      end
      FSEL_CENTER_Y: begin
        num_sel = NUM_W'({1'b0, min_y_r} + {1'b0, max_y_r}) << 15;
        den_sel = height_r;
      end
      FSEL_HEIGHT: begin
        num_sel = NUM_W'(max_y_r - min_y_r) << 16;
        den_sel = height_r;
      end
      FSEL_WIDTH: begin
        num_sel = NUM_W'(max_x_r - min_x_r) << 16;
        den_sel = width_r;
      end
      default: begin
        num_sel = '0;
        den_sel = '0;
      end
    endcase
  end

  // restoring divide, one quotient bit a cycle; a zero divisor yields all ones
  assign rem_s  = {rem_r, num_r[NUM_W-1]};
  assign q_bit  = rem_s >= {1'b0, den_r};
  assign q_full = {q_r[NUM_W-2:0], q_bit};
  assign q_sat  = (|q_full[NUM_W-1:FRAC_W]) ? {FRAC_W{1'b1}} : q_full[FRAC_W-1:0];

  always_comb begin
    status.cnt_zero  = cnt_r == '0;
    status.cnt_full  = cnt_r == CNT_W'(MAX_POINTS);
    status.last      = last_r;
    status.axis      = axis_r;
    status.gt        = rdata > val;
    status.pos_one   = pos_r == CNT_W'(1);
    status.div_last  = step_r == STEP_W'(NUM_W - 1);
    status.fsel_last = fsel_r == FSEL_WIDTH;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r <= REG_W'(1280);
      width_r  <= REG_W'(720);
      cnt_r    <= '0;
      drop_r   <= 1'b0;
      axis_r   <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_SCREEN_HEIGHT) height_r <= cfg_wdata;
      if (cfg_we && cfg_index == REG_SCREEN_WIDTH)  width_r  <= cfg_wdata;
      if (cmd.load) begin
        axis_r <= 1'b0;
        if (cnt_r == CNT_W'(MAX_POINTS)) drop_r <= 1'b1;
      end
      if (cmd.axis_done) begin
        axis_r <= ~axis_r;
        if (axis_r) cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.finish) begin
        cnt_r  <= '0;
        drop_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xv_r   <= in_x_coord;
      yv_r   <= in_y_coord;
      last_r <= in_is_last;
    end
    if (cmd.sort_init) pos_r <= cnt_r;
    if (cmd.sort_cmp && status.gt) pos_r <= pos_r - 1'b1;
    if (cmd.fin_rd1) begin
      min_x_r <= x_rdata;
      min_y_r <= y_rdata;
    end
    if (cmd.fin_rd2) begin
      max_x_r <= x_rdata;
      max_y_r <= y_rdata;
      fsel_r  <= FSEL_CENTER_X;
    end
    if (cmd.div_load) begin
      num_r  <= num_sel;
      den_r  <= den_sel;
      rem_r  <= '0;
      q_r    <= '0;
      step_r <= '0;
    end
    if (cmd.div_step) begin
      num_r  <= num_r << 1;
      rem_r  <= q_bit ? REG_W'(rem_s - {1'b0, den_r}) : REG_W'(rem_s);
      q_r    <= q_full;
      step_r <= step_r + 1'b1;
      if (status.div_last) begin
        fsel_r <= fsel_r + 1'b1;
        case (fsel_r)
          FSEL_CENTER_X: cx_r <= q_sat;
          FSEL_CENTER_Y: cy_r <= q_sat;
          FSEL_HEIGHT:   hf_r <= q_sat;
          FSEL_WIDTH:    wf_r <= q_sat;
          default:       cx_r <= q_sat;
        endcase
      end
    end
  end

  assign out_center_x    = cx_r;
  assign out_center_y    = cy_r;
  assign out_height_frac = hf_r;
  assign out_width_frac  = wf_r;
  assign out_overflowed  = drop_r;

endmodule

>>> rtl/core/trimmed_percentile_bounding_box_core.sv
// Trimmed bounding box of a touch gesture.
// Input channel: a request (in_x_coord, in_y_coord, in_is_last) is taken on
// a rising edge with start high and busy low. Each point is insertion-sorted
// into two 1024-entry RAMs, x then y; each axis passes an init step, the
// compare steps (one per stored entry larger than the new value, plus one
// when an entry that is not larger stops the scan), a write step and an
// axis-done step; a dropped point skips the sort at its init step.
// The compare/shift loop runs on the single read port of each RAM.
// On a point with in_is_last high, k = n/10 entries are trimmed at each end,
// four fractions are found by one shared 28-step restoring divider, and the
// result appears on the out_ ports for one cycle with out_valid high. The
// receiver cannot stall; read the result in that cycle. Points beyond 1024 are
// dropped and flagged on out_overflowed.
// Configuration: cfg_we with cfg_index 0 (screen height) or 1 (screen width)
// writes cfg_wdata; write only while busy is low.
// Reset (rst_n low, synchronous) empties the run; height 1280, width 720.
// No RAM clearing pass: only entries written in the current run are read.
module trimmed_percentile_bounding_box_core
  import trpbb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [COORD_BITS-1:0] in_x_coord,
  input  logic [COORD_BITS-1:0] in_y_coord,
  input  logic                  in_is_last,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [REG_W-1:0]      cfg_wdata,
  output logic                  out_valid,
  output logic [FRAC_W-1:0]     out_center_x,
  output logic [FRAC_W-1:0]     out_center_y,
  output logic [FRAC_W-1:0]     out_height_frac,
  output logic [FRAC_W-1:0]     out_width_frac,
  output logic                  out_overflowed
);

  cmd_t    cmd;
  status_t status;

  // sequence the sort, trim and divide steps
  trpbb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // hold sorted stores, counters, divider and result registers
  trpbb_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_x_coord      (in_x_coord),
    .in_y_coord      (in_y_coord),
    .in_is_last      (in_is_last),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .out_center_x    (out_center_x),
    .out_center_y    (out_center_y),
    .out_height_frac (out_height_frac),
    .out_width_frac  (out_width_frac),
    .out_overflowed  (out_overflowed)
  );

endmodule
